FILE: rtl/tdac_pkg.sv
package tdac_pkg;

  localparam int unsigned HOURS_PER_DAY    = 24;
  localparam int unsigned MINUTES_PER_HOUR = 60;
  localparam int unsigned HALF_DAY         = 12;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_ADD_MIN = 3'd1,
    OP_SUB_MIN = 3'd2,
    OP_ADD_HR  = 3'd3,
    OP_SUB_HR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO       = 2'd1,
    ST_RANGE      = 2'd2
  } status_t;

  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h67;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    priority if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] t10;
    logic [5:0] diff;
    t10  = {t, 3'b000} + {2'b00, t, 1'b0};
    diff = v - t10;
    return diff[3:0];
  endfunction

endpackage

FILE: rtl/time_of_day_adjust_clock_core.sv
// Time-of-day clock with adjust commands and seven-segment digit outputs.
// Input channel (in_valid / in_stall): one command word carrying operation,
// amount, set_hours and set_minutes. Result channel (out_valid / out_stall):
// one result word per command with status, day-change flag, stored time,
// display hours, PM flag and four digit segment patterns.
// cfg_write_en / cfg_write_data select 12-hour display (1) or 24-hour (0);
// write only while no command is in flight.
// An accepted command enters the input register; its result is loaded into
// the output register once that register is empty or not stalled, and is
// shown from then on. Throughput: one command per cycle while the receiver
// does not stall; the time update is one add or subtract with one wrap
// correction between the input and output registers, and the stored time is
// updated as the result loads, so the following command sees it at once.
// Reset (rst_n low, synchronous) clears the time to 00:00, selects 24-hour
// display and empties both registers.
// When the receiver stalls, the result word holds; the input register still
// takes one more command, after which in_stall rises until the result moves.
module time_of_day_adjust_clock_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [9:0] in_amount,
  input  logic [4:0] in_set_hours,
  input  logic [5:0] in_set_minutes,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_day_changed,
  output logic [4:0] out_hours_now,
  output logic [5:0] out_minutes_now,
  output logic [4:0] out_shown_hours,
  output logic       out_is_pm,
  output logic [6:0] out_hour_tens_segments,
  output logic [6:0] out_hour_ones_segments,
  output logic [6:0] out_minute_tens_segments,
  output logic [6:0] out_minute_ones_segments
);

  logic       twelve_r;
  logic [4:0] hour_r;
  logic [5:0] minute_r;

  logic       s1_valid_r;
  logic [2:0] s1_op_r;
  logic [9:0] s1_amount_r;
  logic [4:0] s1_set_hours_r;
  logic [5:0] s1_set_minutes_r;

  logic       out_valid_r;
  logic [1:0] status_r;
  logic       day_r;
  logic [4:0] hours_now_r;
  logic [5:0] minutes_now_r;
  logic [4:0] shown_r;
  logic       pm_r;
  logic [6:0] hr_tens_seg_r;
  logic [6:0] hr_ones_seg_r;
  logic [6:0] mn_tens_seg_r;
  logic [6:0] mn_ones_seg_r;

  logic       s1_adv;
  logic       in_accept;

  logic [1:0] status_nxt;
  logic       day_nxt;
  logic [4:0] hour_nxt;
  logic [5:0] minute_nxt;
  logic [4:0] shown_nxt;

  logic [6:0]  div_x;
  logic [14:0] div_prod;
  logic [5:0]  div_q;
  logic [6:0]  div_rem;
  logic [4:0]  amt_mod24;
  logic [5:0]  amt_min;
  logic [6:0]  min_sum;
  logic [6:0]  min_borrow;
  logic [5:0]  hr_sum;
  logic [5:0]  hr_diff;
  logic [10:0] hr_total;
  logic [2:0]  hr_tens;
  logic [2:0]  mn_tens;

  function automatic logic [4:0] in_set_hours_sat(input logic [4:0] v);
    return (v > 5'(tdac_pkg::HOURS_PER_DAY - 1)) ? 5'(tdac_pkg::HOURS_PER_DAY - 1) : v;
  endfunction

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // amount mod 24 = low three bits plus eight times (amount >> 3) mod 3
  assign div_x     = s1_amount_r[9:3];
  assign div_prod  = 15'(div_x) * 15'd171;
  assign div_q     = div_prod[14:9];
  assign div_rem   = div_x - (7'({div_q, 1'b0}) + 7'(div_q));
  assign amt_mod24 = {div_rem[1:0], s1_amount_r[2:0]};

  assign amt_min    = s1_amount_r[5:0];
  assign min_sum    = {1'b0, minute_r} + {1'b0, amt_min};
  assign min_borrow = {1'b0, minute_r} + 7'(tdac_pkg::MINUTES_PER_HOUR) - {1'b0, amt_min};
  assign hr_sum     = {1'b0, hour_r} + {1'b0, amt_mod24};
  assign hr_diff    = (hour_r >= amt_mod24) ? ({1'b0, hour_r} - {1'b0, amt_mod24})
                    : ({1'b0, hour_r} + 6'(tdac_pkg::HOURS_PER_DAY) - {1'b0, amt_mod24});
  assign hr_total   = {6'b0, hour_r} + {1'b0, s1_amount_r};

  always_comb begin
    status_nxt = tdac_pkg::ST_OK;
    day_nxt    = 1'b0;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    unique case (s1_op_r)
      tdac_pkg::OP_LOAD: begin
        hour_nxt   = (in_set_hours_sat(s1_set_hours_r));
        minute_nxt = (s1_set_minutes_r > 6'(tdac_pkg::MINUTES_PER_HOUR - 1))
                   ? 6'(tdac_pkg::MINUTES_PER_HOUR - 1) : s1_set_minutes_r;
      end
      tdac_pkg::OP_ADD_MIN, tdac_pkg::OP_SUB_MIN, tdac_pkg::OP_ADD_HR,
      tdac_pkg::OP_SUB_HR: begin
        priority if (s1_amount_r == 10'd0) begin
          status_nxt = tdac_pkg::ST_ZERO;
        end else if (s1_op_r == tdac_pkg::OP_ADD_MIN || s1_op_r == tdac_pkg::OP_SUB_MIN) begin
          priority if (s1_amount_r > 10'(tdac_pkg::MINUTES_PER_HOUR)) begin
            status_nxt = tdac_pkg::ST_RANGE;
          end else if (s1_op_r == tdac_pkg::OP_ADD_MIN) begin
            if (min_sum >= 7'(tdac_pkg::MINUTES_PER_HOUR)) begin
              minute_nxt = 6'(min_sum - 7'(tdac_pkg::MINUTES_PER_HOUR));
              if (hour_r == 5'(tdac_pkg::HOURS_PER_DAY - 1)) begin
                hour_nxt = 5'd0;
                day_nxt  = 1'b1;
              end else begin
                hour_nxt = hour_r + 5'd1;
              end
            end else begin
              minute_nxt = min_sum[5:0];
            end
          end else begin
            if (amt_min > minute_r) begin
              minute_nxt = min_borrow[5:0];
              if (hour_r == 5'd0) begin
                hour_nxt = 5'(tdac_pkg::HOURS_PER_DAY - 1);
                day_nxt  = 1'b1;
              end else begin
                hour_nxt = hour_r - 5'd1;
              end
            end else begin
              minute_nxt = minute_r - amt_min;
            end
          end
        end else if (s1_op_r == tdac_pkg::OP_ADD_HR) begin
          day_nxt  = hr_total >= 11'(tdac_pkg::HOURS_PER_DAY);
          hour_nxt = (hr_sum >= 6'(tdac_pkg::HOURS_PER_DAY))
                   ? 5'(hr_sum - 6'(tdac_pkg::HOURS_PER_DAY)) : hr_sum[4:0];
        end else begin
          day_nxt  = s1_amount_r > {5'b0, hour_r};
          hour_nxt = hr_diff[4:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    shown_nxt = hour_nxt;
    if (twelve_r) begin
      if (hour_nxt == 5'd0) begin
        shown_nxt = 5'(tdac_pkg::HALF_DAY);
      end else if (hour_nxt > 5'(tdac_pkg::HALF_DAY)) begin
        shown_nxt = hour_nxt - 5'(tdac_pkg::HALF_DAY);
      end
    end
  end

  assign hr_tens = tdac_pkg::tens_of({1'b0, shown_nxt});
  assign mn_tens = tdac_pkg::tens_of(minute_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twelve_r    <= 1'b0;
      hour_r      <= 5'd0;
      minute_r    <= 6'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        twelve_r <= cfg_write_data;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r          <= in_operation;
      s1_amount_r      <= in_amount;
      s1_set_hours_r   <= in_set_hours;
      s1_set_minutes_r <= in_set_minutes;
    end
    if (s1_adv) begin
      status_r      <= status_nxt;
      day_r         <= day_nxt;
      hours_now_r   <= hour_nxt;
      minutes_now_r <= minute_nxt;
      shown_r       <= shown_nxt;
      pm_r          <= hour_nxt >= 5'(tdac_pkg::HALF_DAY);
      hr_tens_seg_r <= tdac_pkg::seg_of({1'b0, hr_tens});
      hr_ones_seg_r <= tdac_pkg::seg_of(tdac_pkg::ones_of({1'b0, shown_nxt}, hr_tens));
      mn_tens_seg_r <= tdac_pkg::seg_of({1'b0, mn_tens});
      mn_ones_seg_r <= tdac_pkg::seg_of(tdac_pkg::ones_of(minute_nxt, mn_tens));
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = status_r;
  assign out_day_changed          = day_r;
  assign out_hours_now            = hours_now_r;
  assign out_minutes_now          = minutes_now_r;
  assign out_shown_hours          = shown_r;
  assign out_is_pm                = pm_r;
  assign out_hour_tens_segments   = hr_tens_seg_r;
  assign out_hour_ones_segments   = hr_ones_seg_r;
  assign out_minute_tens_segments = mn_tens_seg_r;
  assign out_minute_ones_segments = mn_ones_seg_r;

endmodule

FILE: rtl/tdac_checker.sv
module tdac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_day_changed,
  input logic [4:0] out_hours_now,
  input logic [5:0] out_minutes_now,
  input logic       out_is_pm
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hours_now) &&
      $stable(out_minutes_now) && $stable(out_status))
    else $error("stalled result word changed");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hours_now < 5'd24 && out_minutes_now < 6'd60)
    else $error("stored time out of range");

  a_no_wrap_unapplied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tdac_pkg::ST_OK |-> !out_day_changed &&
      out_status != 2'd3)
    else $error("day change on a rejected command");

  a_pm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_pm == (out_hours_now >= 5'd12))
    else $error("pm flag disagrees with stored hours");

endmodule

bind time_of_day_adjust_clock_core tdac_checker u_tdac_checker (.*);
